/* sv/spd_pkg.sv */
package spd_pkg;

	// Default geometry of the block
	localparam int COORD_BITS_DEF = 17;
	localparam int FRAC_BITS_DEF  = 16;
	localparam int OUT_BITS       = 34;

	// Derived defaults for the arithmetic units
	localparam int DIV_DEN_BITS_DEF = 2 * (COORD_BITS_DEF + 1);
	localparam int DIV_QUO_BITS_DEF = DIV_DEN_BITS_DEF + 2 * FRAC_BITS_DEF;
	localparam int DIV_NUM_BITS_DEF = DIV_DEN_BITS_DEF + DIV_QUO_BITS_DEF;
	localparam int SQRT_BITS_DEF    = (DIV_QUO_BITS_DEF + 1) / 2;

	typedef logic [2:0] vec_idx_t;

	// Difference vectors between the endpoints
	localparam int NUM_VECS = 6;
	localparam vec_idx_t VEC_AB = 3'd0; // B - A
	localparam vec_idx_t VEC_AC = 3'd1; // C - A
	localparam vec_idx_t VEC_AD = 3'd2; // D - A
	localparam vec_idx_t VEC_CD = 3'd3; // D - C
	localparam vec_idx_t VEC_CB = 3'd4; // B - C
	localparam vec_idx_t VEC_BD = 3'd5; // D - B

	// Cross (CR), dot (DT) and squared length (LN) terms
	localparam int NUM_TERMS  = 26;
	localparam int T_CR_AB_AC = 0;
	localparam int T_CR_AB_AD = 1;
	localparam int T_CR_CD_AC = 2;
	localparam int T_CR_CD_CB = 3;
	localparam int T_CR_AC_CB = 4;
	localparam int T_DT_AC_CB = 5;
	localparam int T_CR_AD_BD = 6;
	localparam int T_DT_AD_BD = 7;
	localparam int T_CR_AC_AD = 8;
	localparam int T_DT_AC_AD = 9;
	localparam int T_CR_CB_BD = 10;
	localparam int T_DT_CB_BD = 11;
	localparam int T_DT_AC_AB = 12;
	localparam int T_DT_CB_AB = 13;
	localparam int T_DT_AD_AB = 14;
	localparam int T_DT_BD_AB = 15;
	localparam int T_DT_AC_CD = 16;
	localparam int T_DT_AD_CD = 17;
	localparam int T_DT_CB_CD = 18;
	localparam int T_DT_BD_CD = 19;
	localparam int T_LN_AC    = 20;
	localparam int T_LN_AD    = 21;
	localparam int T_LN_CB    = 22;
	localparam int T_LN_BD    = 23;
	localparam int T_LN_AB    = 24;
	localparam int T_LN_CD    = 25;

	localparam vec_idx_t TERM_U [NUM_TERMS] = '{
		VEC_AB, VEC_AB, VEC_CD, VEC_CD, VEC_AC, VEC_AC, VEC_AD, VEC_AD,
		VEC_AC, VEC_AC, VEC_CB, VEC_CB, VEC_AC, VEC_CB, VEC_AD, VEC_BD,
		VEC_AC, VEC_AD, VEC_CB, VEC_BD, VEC_AC, VEC_AD, VEC_CB, VEC_BD,
		VEC_AB, VEC_CD
	};

	localparam vec_idx_t TERM_V [NUM_TERMS] = '{
		VEC_AC, VEC_AD, VEC_AC, VEC_CB, VEC_CB, VEC_CB, VEC_BD, VEC_BD,
		VEC_AD, VEC_AD, VEC_BD, VEC_BD, VEC_AB, VEC_AB, VEC_AB, VEC_AB,
		VEC_CD, VEC_CD, VEC_CD, VEC_CD, VEC_AC, VEC_AD, VEC_CB, VEC_BD,
		VEC_AB, VEC_CD
	};

	localparam logic [NUM_TERMS-1:0] TERM_IS_DOT = 26'b11_1111_1111_1111_1010_1010_0000;

endpackage

/* sv/spd_if.sv */
interface spd_pair_if #(
	parameter int COORD_BITS = spd_pkg::COORD_BITS_DEF
);
	logic valid;
	logic ready;
	logic signed [COORD_BITS-1:0] a_x;
	logic signed [COORD_BITS-1:0] a_y;
	logic signed [COORD_BITS-1:0] b_x;
	logic signed [COORD_BITS-1:0] b_y;
	logic signed [COORD_BITS-1:0] c_x;
	logic signed [COORD_BITS-1:0] c_y;
	logic signed [COORD_BITS-1:0] d_x;
	logic signed [COORD_BITS-1:0] d_y;

	modport source (output valid, a_x, a_y, b_x, b_y, c_x, c_y, d_x, d_y, input ready);
	modport sink (input valid, a_x, a_y, b_x, b_y, c_x, c_y, d_x, d_y, output ready);
endinterface

interface spd_result_if;
	logic valid;
	logic ready;
	logic [spd_pkg::OUT_BITS-1:0] distance;
	logic touching;

	modport source (output valid, distance, touching, input ready);
	modport sink (input valid, distance, touching, output ready);
endinterface

/* sv/spd_div.sv */
module spd_div #(
	parameter int NW = spd_pkg::DIV_NUM_BITS_DEF,
	parameter int DW = spd_pkg::DIV_DEN_BITS_DEF,
	parameter int QW = spd_pkg::DIV_QUO_BITS_DEF
) (
	input  logic          clk,
	input  logic          en,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	output logic [QW-1:0] quo
);

	// Restoring divider, one quotient bit per stage; the upper DW bits of
	// num are below den by construction, so they seed the remainder.
	logic [DW-1:0] rem_s [QW-1];
	logic [DW-1:0] den_s [QW-1];
	logic [QW-1:0] nq_s  [QW];

	for (genvar i = 0; i < QW; i++) begin : g_stage
		logic [DW-1:0] rem_i;
		logic [DW-1:0] den_i;
		logic [QW-1:0] nq_i;
		logic [DW:0]   t;
		logic [DW:0]   diff;
		logic          ge;

		if (i == 0) begin : g_first
			assign rem_i = num[NW-1:QW];
			assign den_i = den;
			assign nq_i  = num[QW-1:0];
		end else begin : g_next
			assign rem_i = rem_s[i-1];
			assign den_i = den_s[i-1];
			assign nq_i  = nq_s[i-1];
		end

		// Shift in the next numerator bit and try a subtract
		assign t    = {rem_i, nq_i[QW-1]};
		assign diff = t - {1'b0, den_i};
		assign ge   = (t >= {1'b0, den_i});

		always_ff @(posedge clk) begin
			if (en) begin
				nq_s[i] <= {nq_i[QW-2:0], ge};
			end
		end

		if (i < QW - 1) begin : g_carry
			always_ff @(posedge clk) begin
				if (en) begin
					rem_s[i] <= ge ? diff[DW-1:0] : t[DW-1:0];
					den_s[i] <= den_i;
				end
			end
		end
	end

	assign quo = nq_s[QW-1];

endmodule

/* sv/spd_sqrt.sv */
module spd_sqrt #(
	parameter int SW = spd_pkg::SQRT_BITS_DEF
) (
	input  logic            clk,
	input  logic            en,
	input  logic [2*SW-1:0] rad,
	output logic [SW-1:0]   root
);

	localparam int RW = 2 * SW;

	// Digit-by-digit square root, one root bit per stage
	logic [SW:0]   rem_s  [SW-1];
	logic [RW-1:0] rad_s  [SW-1];
	logic [SW-1:0] root_s [SW];

	for (genvar i = 0; i < SW; i++) begin : g_stage
		logic [SW:0]   rem_i;
		logic [RW-1:0] rad_i;
		logic [SW-1:0] root_i;
		logic [SW+2:0] t;
		logic [SW+2:0] trial;
		logic [SW+2:0] diff;
		logic          ge;

		if (i == 0) begin : g_first
			assign rem_i  = '0;
			assign rad_i  = rad;
			assign root_i = '0;
		end else begin : g_next
			assign rem_i  = rem_s[i-1];
			assign rad_i  = rad_s[i-1];
			assign root_i = root_s[i-1];
		end

		// Bring down two radicand bits and test root*4+1
		assign t     = {rem_i, rad_i[RW-1:RW-2]};
		assign trial = {1'b0, root_i, 2'b01};
		assign diff  = t - trial;
		assign ge    = (t >= trial);

		always_ff @(posedge clk) begin
			if (en) begin
				root_s[i] <= {root_i[SW-2:0], ge};
			end
		end

		if (i < SW - 1) begin : g_carry
			always_ff @(posedge clk) begin
				if (en) begin
					rem_s[i] <= ge ? diff[SW:0] : t[SW:0];
					rad_s[i] <= rad_i << 2;
				end
			end
		end
	end

	assign root = root_s[SW-1];

endmodule

/* sv/segment_pair_distance.sv */
// Shortest distance between two integer segments AB and CD.
// pair channel: one item holds the endpoints A, B, C, D; it is taken at a
// clock edge with valid and ready both high.
// result channel: one item per pair, distance in unsigned fixed point with
// FRAC_BITS fraction bits (truncated, saturating), and touching, which is
// set when the segments meet; distance is then zero.
// From accept to result valid an item passes the front stages, the
// restoring divider (one quotient bit per stage), the minimum and the
// square root (one root bit per stage).
// Throughput: one pair per cycle while the pipe is not frozen; every stage
// is a register and the whole pipe advances together.
// Reset clears every valid bit; nothing is in flight afterwards.
// When the result receiver holds ready low on a valid result, the pipe
// freezes: pair.ready drops, nothing is lost or repeated, and it resumes
// as soon as the result is taken. Bubbles in the pipe never block entry.
module segment_pair_distance #(
	parameter int COORD_BITS = spd_pkg::COORD_BITS_DEF,
	parameter int FRAC_BITS  = spd_pkg::FRAC_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	spd_pair_if.sink pair,
	spd_result_if.source result
);

	localparam int DW  = COORD_BITS + 1;
	localparam int PW  = 2 * DW;
	localparam int TW  = PW + 1;
	localparam int MW  = PW;
	localparam int HW  = MW / 2;
	localparam int GW  = MW - HW;
	localparam int SQW = 2 * MW;
	localparam int NW  = SQW + 2 * FRAC_BITS;
	localparam int QW  = NW - MW;
	localparam int SW  = (QW + 1) / 2;
	localparam int RW  = 2 * SW;
	localparam int LAT = 6 + QW + 2 + SW;
	localparam int NT  = spd_pkg::NUM_TERMS;
	localparam int NV  = spd_pkg::NUM_VECS;
	localparam int OW  = spd_pkg::OUT_BITS;

	typedef struct packed {
		logic          ep;
		logic [MW-1:0] val;
		logic [MW-1:0] den;
	} seg_sel_t;

	logic en;
	logic [LAT-1:0] vld_q;

	logic signed [DW-1:0] vx_s1 [NV];
	logic signed [DW-1:0] vy_s1 [NV];
	logic signed [PW-1:0] p0_s2 [NT];
	logic signed [PW-1:0] p1_s2 [NT];
	logic signed [TW-1:0] t_s3  [NT];

	logic           touch_c;
	seg_sel_t       sel_c [4];
	logic           tch_s4;
	logic [3:0]     ep_s4;
	logic [MW-1:0]  val_s4 [4];
	logic [MW-1:0]  den_s4 [4];

	logic           tch_s5;
	logic [3:0]     ep_s5;
	logic [MW-1:0]  val_s5 [4];
	logic [MW-1:0]  den_s5 [4];
	logic [2*GW-1:0]  hh_s5 [4];
	logic [GW+HW-1:0] hl_s5 [4];
	logic [2*HW-1:0]  ll_s5 [4];

	logic           tch_s6;
	logic [SQW-1:0] num_s6 [4];
	logic [MW-1:0]  den_s6 [4];

	logic [QW-1:0]  quo [4];
	logic [QW-1:0]  tch_dv_q;
	logic [QW-1:0]  mn01_m1;
	logic [QW-1:0]  mn23_m1;
	logic           tch_m1;
	logic [QW-1:0]  q_m2;
	logic           tch_m2;
	logic [SW-1:0]  tch_sq_q;
	logic [SW-1:0]  root;

	// Advance the whole pipe unless a finished result waits
	assign en         = !vld_q[LAT-1] || result.ready;
	assign pair.ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[LAT-2:0], pair.valid};
		end
	end

	// Stage 1: difference vectors
	always_ff @(posedge clk) begin
		if (en) begin
			vx_s1[spd_pkg::VEC_AB] <= DW'(pair.b_x) - DW'(pair.a_x);
			vy_s1[spd_pkg::VEC_AB] <= DW'(pair.b_y) - DW'(pair.a_y);
			vx_s1[spd_pkg::VEC_AC] <= DW'(pair.c_x) - DW'(pair.a_x);
			vy_s1[spd_pkg::VEC_AC] <= DW'(pair.c_y) - DW'(pair.a_y);
			vx_s1[spd_pkg::VEC_AD] <= DW'(pair.d_x) - DW'(pair.a_x);
			vy_s1[spd_pkg::VEC_AD] <= DW'(pair.d_y) - DW'(pair.a_y);
			vx_s1[spd_pkg::VEC_CD] <= DW'(pair.d_x) - DW'(pair.c_x);
			vy_s1[spd_pkg::VEC_CD] <= DW'(pair.d_y) - DW'(pair.c_y);
			vx_s1[spd_pkg::VEC_CB] <= DW'(pair.b_x) - DW'(pair.c_x);
			vy_s1[spd_pkg::VEC_CB] <= DW'(pair.b_y) - DW'(pair.c_y);
			vx_s1[spd_pkg::VEC_BD] <= DW'(pair.d_x) - DW'(pair.b_x);
			vy_s1[spd_pkg::VEC_BD] <= DW'(pair.d_y) - DW'(pair.b_y);
		end
	end

	// Stages 2 and 3: products, then cross and dot sums
	for (genvar k = 0; k < NT; k++) begin : g_term
		localparam int U = int'(spd_pkg::TERM_U[k]);
		localparam int V = int'(spd_pkg::TERM_V[k]);

		if (spd_pkg::TERM_IS_DOT[k]) begin : g_dot
			always_ff @(posedge clk) begin
				if (en) begin
					p0_s2[k] <= PW'(vx_s1[U]) * PW'(vx_s1[V]);
					p1_s2[k] <= PW'(vy_s1[U]) * PW'(vy_s1[V]);
					t_s3[k]  <= TW'(p0_s2[k]) + TW'(p1_s2[k]);
				end
			end
		end else begin : g_cross
			always_ff @(posedge clk) begin
				if (en) begin
					p0_s2[k] <= PW'(vx_s1[U]) * PW'(vy_s1[V]);
					p1_s2[k] <= PW'(vy_s1[U]) * PW'(vx_s1[V]);
					t_s3[k]  <= TW'(p0_s2[k]) - TW'(p1_s2[k]);
				end
			end
		end
	end

	// Pick endpoint distance or perpendicular ratio for one point
	function automatic seg_sel_t seg_sel(
		input logic near_out,
		input logic far_out,
		input logic signed [TW-1:0] ln_near,
		input logic signed [TW-1:0] ln_far,
		input logic signed [TW-1:0] crs,
		input logic signed [TW-1:0] ln_seg
	);
		seg_sel_t s;
		s.ep  = 1'b1;
		s.den = MW'(1);
		if (near_out) begin
			s.val = MW'(ln_near);
		end else if (far_out) begin
			s.val = MW'(ln_far);
		end else begin
			s.ep  = 1'b0;
			s.val = crs[TW-1] ? MW'(-crs) : MW'(crs);
			s.den = MW'(ln_seg);
		end
		return s;
	endfunction

	// Stage 4: touch decision and the four point-to-segment cases
	always_comb begin
		logic same_ab;
		logic same_cd;
		logic coll;
		logic onp;
		same_ab = (t_s3[spd_pkg::T_CR_AB_AC] > 0 && t_s3[spd_pkg::T_CR_AB_AD] > 0) ||
		          (t_s3[spd_pkg::T_CR_AB_AC] < 0 && t_s3[spd_pkg::T_CR_AB_AD] < 0);
		same_cd = (t_s3[spd_pkg::T_CR_CD_AC] < 0 && t_s3[spd_pkg::T_CR_CD_CB] > 0) ||
		          (t_s3[spd_pkg::T_CR_CD_AC] > 0 && t_s3[spd_pkg::T_CR_CD_CB] < 0);
		coll = t_s3[spd_pkg::T_CR_AB_AC] == 0 && t_s3[spd_pkg::T_CR_AB_AD] == 0 &&
		       t_s3[spd_pkg::T_CR_CD_AC] == 0 && t_s3[spd_pkg::T_CR_CD_CB] == 0;
		onp = (t_s3[spd_pkg::T_CR_AC_CB] == 0 && t_s3[spd_pkg::T_DT_AC_CB] >= 0) ||
		      (t_s3[spd_pkg::T_CR_AD_BD] == 0 && t_s3[spd_pkg::T_DT_AD_BD] <= 0) ||
		      (t_s3[spd_pkg::T_CR_AC_AD] == 0 && t_s3[spd_pkg::T_DT_AC_AD] <= 0) ||
		      (t_s3[spd_pkg::T_CR_CB_BD] == 0 && t_s3[spd_pkg::T_DT_CB_BD] >= 0);
		touch_c = coll ? onp : (!same_ab && !same_cd);

		sel_c[0] = seg_sel(t_s3[spd_pkg::T_DT_AC_AB] <= 0, t_s3[spd_pkg::T_DT_CB_AB] <= 0,
			t_s3[spd_pkg::T_LN_AC], t_s3[spd_pkg::T_LN_CB],
			t_s3[spd_pkg::T_CR_AB_AC], t_s3[spd_pkg::T_LN_AB]);
		sel_c[1] = seg_sel(t_s3[spd_pkg::T_DT_AD_AB] <= 0, t_s3[spd_pkg::T_DT_BD_AB] >= 0,
			t_s3[spd_pkg::T_LN_AD], t_s3[spd_pkg::T_LN_BD],
			t_s3[spd_pkg::T_CR_AB_AD], t_s3[spd_pkg::T_LN_AB]);
		sel_c[2] = seg_sel(t_s3[spd_pkg::T_DT_AC_CD] >= 0, t_s3[spd_pkg::T_DT_AD_CD] <= 0,
			t_s3[spd_pkg::T_LN_AC], t_s3[spd_pkg::T_LN_AD],
			t_s3[spd_pkg::T_CR_CD_AC], t_s3[spd_pkg::T_LN_CD]);
		sel_c[3] = seg_sel(t_s3[spd_pkg::T_DT_CB_CD] <= 0, t_s3[spd_pkg::T_DT_BD_CD] <= 0,
			t_s3[spd_pkg::T_LN_CB], t_s3[spd_pkg::T_LN_BD],
			t_s3[spd_pkg::T_CR_CD_CB], t_s3[spd_pkg::T_LN_CD]);
	end

	// Stages 4 to 6: register the cases, square the cross magnitude in halves, sum
	always_ff @(posedge clk) begin
		if (en) begin
			tch_s4 <= touch_c;
			tch_s5 <= tch_s4;
			tch_s6 <= tch_s5;
			for (int i = 0; i < 4; i++) begin
				ep_s4[i]  <= sel_c[i].ep;
				val_s4[i] <= sel_c[i].val;
				den_s4[i] <= sel_c[i].den;

				ep_s5[i]  <= ep_s4[i];
				val_s5[i] <= val_s4[i];
				den_s5[i] <= den_s4[i];
				hh_s5[i]  <= val_s4[i][MW-1:HW] * val_s4[i][MW-1:HW];
				hl_s5[i]  <= val_s4[i][MW-1:HW] * val_s4[i][HW-1:0];
				ll_s5[i]  <= val_s4[i][HW-1:0] * val_s4[i][HW-1:0];

				num_s6[i] <= ep_s5[i] ? SQW'(val_s5[i]) :
					(SQW'(hh_s5[i]) << (2 * HW)) + (SQW'(hl_s5[i]) << (HW + 1)) +
					SQW'(ll_s5[i]);
				den_s6[i] <= den_s5[i];
			end
		end
	end

	// Divide each squared distance numerator by its squared segment length (one for an endpoint)
	for (genvar i = 0; i < 4; i++) begin : g_div
		spd_div #(
			.NW(NW),
			.DW(MW),
			.QW(QW)
		) u_div (
			.clk(clk),
			.en (en),
			.num(NW'(num_s6[i]) << (2 * FRAC_BITS)),
			.den(den_s6[i]),
			.quo(quo[i])
		);
	end

	// Carry the touch flag alongside the divider and root
	always_ff @(posedge clk) begin
		if (en) begin
			tch_dv_q <= {tch_dv_q[QW-2:0], tch_s6};
			tch_sq_q <= {tch_sq_q[SW-2:0], tch_m2};
		end
	end

	// Two-level minimum, zero when touching
	always_ff @(posedge clk) begin
		if (en) begin
			mn01_m1 <= (quo[1] < quo[0]) ? quo[1] : quo[0];
			mn23_m1 <= (quo[3] < quo[2]) ? quo[3] : quo[2];
			tch_m1  <= tch_dv_q[QW-1];
			q_m2    <= tch_m1 ? '0 : ((mn23_m1 < mn01_m1) ? mn23_m1 : mn01_m1);
			tch_m2  <= tch_m1;
		end
	end

	spd_sqrt #(
		.SW(SW)
	) u_sqrt (
		.clk (clk),
		.en  (en),
		.rad (RW'(q_m2)),
		.root(root)
	);

	// Saturate to the output width
	if (SW > OW) begin : g_sat
		assign result.distance = (|root[SW-1:OW]) ? '1 : root[OW-1:0];
	end else begin : g_fit
		assign result.distance = OW'(root);
	end

	assign result.touching = tch_sq_q[SW-1];
	assign result.valid    = vld_q[LAT-1];

	a_touch_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.touching |-> result.distance == '0)
		else $error("touching result with nonzero distance");

	a_den_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q[3] |-> (ep_s4[0] || den_s4[0] != '0) && (ep_s4[1] || den_s4[1] != '0) &&
		             (ep_s4[2] || den_s4[2] != '0) && (ep_s4[3] || den_s4[3] != '0))
		else $error("division by a zero segment length");

	a_freeze: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> vld_q == $past(vld_q))
		else $error("pipe moved while stalled");

	a_enter: assert property (@(posedge clk) disable iff (!arst_n)
		pair.valid && pair.ready |=> vld_q[0])
		else $error("accepted item not in first stage");

endmodule
